// ----- hdl/refraction_direction_unit_assert.svh -----
// Assertion macros shared by the refraction direction unit.
`ifndef REFRACTION_DIRECTION_UNIT_ASSERT_SVH
`define REFRACTION_DIRECTION_UNIT_ASSERT_SVH

// Checks that the consequent holds whenever the antecedent holds.
`define RDU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds at every clock edge outside reset.
`define RDU_ASSERT_ALWAYS(lbl, cons, msg) \
  `RDU_ASSERT_IMP(lbl, 1'b1, cons, msg)

`endif

// ----- hdl/rdu_pkg.sv -----
// Constants shared by the refraction direction unit and its arithmetic units.
`default_nettype none
package rdu_pkg;

  localparam int VEC_FRAC_BITS = 14;

  localparam int DIV_QW = 32;
  localparam int DIV_STEPS = 2;
  localparam int DIV_LAT = DIV_QW / DIV_STEPS;

  localparam int SQ_QW = 32;
  localparam int SQ_STEPS = 2;
  localparam int SQ_LAT = SQ_QW / SQ_STEPS;

  localparam int DM_SHR = (2 * VEC_FRAC_BITS >= 24) ? 2 * VEC_FRAC_BITS - 24 : 0;
  localparam int DM_SHL = (2 * VEC_FRAC_BITS < 24) ? 24 - 2 * VEC_FRAC_BITS : 0;

  localparam int NORM_BITS = 30;

  localparam logic [47:0] C_CLAMP = 48'h0000_8000_0000;
  localparam logic [38:0] Q24_ONE = 39'h00_0100_0000;
  localparam logic [70:0] P_CAP = 71'h00_0040_0000_0000_0000;
  localparam logic [56:0] K_ONE = 57'h000_0000_0100_0000;

endpackage
`default_nettype wire

// ----- hdl/refraction_direction_unit.sv -----
// Top level of the refraction direction unit: Snell refraction of a view vector.
//
//   channel   direction   handshake            payload
//   in_       input       in_valid/in_ready    view, normal, back_face, indices
//   out_      output      out_valid/out_ready  dir, refracted, hit_back_next
//
// One transaction is accepted per cycle while in_ready is high; the pipeline runs
// through two 16-stage dividers, two 16-stage square root units and 17 arithmetic stages.
// Reset clears only the valid bits of the pipeline.
// When a result waits on out_ready, every stage holds and in_ready is low.
`default_nettype none
module refraction_direction_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_view_x,
  input  logic signed [15:0] in_view_y,
  input  logic signed [15:0] in_view_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic               in_back_face,
  input  logic [15:0]        in_ray_index,
  input  logic [15:0]        in_material_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dir_x,
  output logic signed [15:0] out_dir_y,
  output logic signed [15:0] out_dir_z,
  output logic               out_refracted,
  output logic               out_hit_back_next
);

  `include "refraction_direction_unit_assert.svh"

  localparam int DL = rdu_pkg::DIV_LAT;
  localparam int SL = rdu_pkg::SQ_LAT;
  localparam int TOTAL = 2 * DL + 2 * SL + 17;
  localparam int POS_L = DL + SL + 11;
  localparam int POS_DQ = 2 * DL + 2 * SL + 15;

  typedef struct packed {
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
    logic [15:0]      ray;
  } s1_t;

  typedef struct packed {
    logic [31:0]      eta;
    logic [2:0][31:0] p;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } sa_t;

  typedef struct packed {
    logic [31:0]      eta;
    logic [55:0]      e2;
    logic [31:0]      dm;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } sb_t;

  typedef struct packed {
    logic [31:0]      eta;
    logic [55:0]      e2;
    logic [38:0]      c2;
    logic [35:0]      etac;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } sc_t;

  typedef struct packed {
    logic [31:0]      eta;
    logic [55:0]      e2;
    logic [38:0]      mt;
    logic             tneg;
    logic [35:0]      etac;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } sd_t;

  typedef struct packed {
    logic [47:0]      ll;
    logic [46:0]      lh;
    logic [47:0]      hl;
    logic [46:0]      hh;
    logic             tneg;
    logic [31:0]      eta;
    logic [35:0]      etac;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } se_t;

  typedef struct packed {
    logic [54:0]      p;
    logic             tneg;
    logic [31:0]      eta;
    logic [35:0]      etac;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } sf_t;

  typedef struct packed {
    logic [55:0]      rad;
    logic             tir;
    logic [31:0]      eta;
    logic [35:0]      etac;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } sg_t;

  typedef struct packed {
    logic             tir;
    logic [31:0]      eta;
    logic [35:0]      etac;
    logic             cneg;
    logic [2:0][15:0] v;
    logic [2:0][15:0] n;
    logic             back;
  } s2_t;

  typedef struct packed {
    logic [37:0]      bsig;
    logic [2:0][45:0] ev;
    logic [2:0][15:0] n;
    logic             tir;
    logic             back;
  } sh_t;

  typedef struct packed {
    logic [2:0][45:0] ev;
    logic [2:0][53:0] bn;
    logic             tir;
    logic             back;
  } si_t;

  typedef struct packed {
    logic [2:0][55:0] r;
    logic             tir;
    logic             back;
  } sj_t;

  typedef struct packed {
    logic [2:0][54:0] mag;
    logic [2:0]       neg;
    logic             tir;
    logic             back;
  } sk_t;

  typedef struct packed {
    logic [2:0][54:0] mag;
    logic [4:0]       s;
    logic [2:0]       neg;
    logic             tir;
    logic             back;
  } sl_t;

  typedef struct packed {
    logic [2:0][29:0] a;
    logic [2:0]       neg;
    logic             tir;
    logic             back;
  } sm_t;

  typedef struct packed {
    logic [2:0][29:0] a;
    logic [2:0][59:0] sq;
    logic [2:0]       neg;
    logic             tir;
    logic             back;
  } sn_t;

  typedef struct packed {
    logic [2:0][29:0] a;
    logic [61:0]      sum;
    logic [2:0]       neg;
    logic             tir;
    logic             back;
  } so_t;

  typedef struct packed {
    logic [2:0][29:0] a;
    logic [2:0]       neg;
    logic             tir;
    logic             back;
  } s3_t;

  typedef struct packed {
    logic [2:0][63:0] num;
    logic [31:0]      den;
    logic [2:0]       neg;
    logic             tir;
    logic             zero;
    logic             back;
  } sp_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       tir;
    logic       zero;
    logic       back;
  } s4_t;

  logic adv;
  logic [TOTAL-1:0] vld_r;
  logic [TOTAL-1:0] vld_nxt;

  s1_t s1_nxt;
  s1_t s1_r [DL];
  sa_t sa_nxt, sa_r;
  sb_t sb_nxt, sb_r;
  sc_t sc_nxt, sc_r;
  sd_t sd_nxt, sd_r;
  se_t se_nxt, se_r;
  sf_t sf_nxt, sf_r;
  sg_t sg_nxt, sg_r;
  s2_t s2_r [SL];
  sh_t sh_nxt, sh_r;
  si_t si_nxt, si_r;
  sj_t sj_nxt, sj_r;
  sk_t sk_nxt, sk_r;
  sl_t sl_nxt, sl_r;
  sm_t sm_nxt, sm_r;
  sn_t sn_nxt, sn_r;
  so_t so_nxt, so_r;
  s3_t s3_r [SL];
  sp_t sp_nxt, sp_r;
  s4_t s4_r [DL];

  logic [2:0][15:0] dir_nxt, dir_r;
  logic             refr_nxt, refr_r;
  logic             hbn_nxt, hbn_r;

  logic [15:0]      ray_fix;
  logic [31:0]      eta_q;
  logic [31:0]      sk_root;
  logic [31:0]      len_root;
  logic [2:0][31:0] quot;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  assign vld_nxt = {vld_r[TOTAL-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Input capture and eta division.
  assign ray_fix = (in_ray_index == 16'd0) ? 16'd1 : in_ray_index;

  always_comb begin
    s1_nxt.v    = {in_view_z, in_view_y, in_view_x};
    s1_nxt.n    = {in_normal_z, in_normal_y, in_normal_x};
    s1_nxt.back = in_back_face;
    s1_nxt.ray  = ray_fix;
  end

  rdu_div u_eta_div (
    .clk  (clk),
    .adv  (adv),
    .num  ({32'b0, in_material_index, 16'b0}),
    .den  ({16'b0, ray_fix}),
    .quot (eta_q)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r[0] <= s1_nxt;
      for (int i = 1; i < DL; i++) begin
        s1_r[i] <= s1_r[i-1];
      end
    end
  end

  // Stage A: eta select and dot product terms.
  always_comb begin
    sa_nxt.eta  = s1_r[DL-1].back ? {12'b0, s1_r[DL-1].ray, 4'b0} : eta_q;
    sa_nxt.v    = s1_r[DL-1].v;
    sa_nxt.n    = s1_r[DL-1].n;
    sa_nxt.back = s1_r[DL-1].back;
    for (int i = 0; i < 3; i++) begin
      sa_nxt.p[i] = $signed(s1_r[DL-1].v[i]) * $signed(s1_r[DL-1].n[i]);
    end
  end

  // Stage B: cosine magnitude and eta squared.
  always_comb begin
    logic [35:0] dot;
    logic [35:0] dmag;
    logic [47:0] dm_wide;
    logic [63:0] eta_sq;
    dot = {{4{sa_r.p[0][31]}}, sa_r.p[0]} + {{4{sa_r.p[1][31]}}, sa_r.p[1]}
        + {{4{sa_r.p[2][31]}}, sa_r.p[2]};
    dmag = dot[35] ? (36'd0 - dot) : dot;
    dm_wide = ({12'b0, dmag} >> rdu_pkg::DM_SHR) << rdu_pkg::DM_SHL;
    eta_sq = 64'(sa_r.eta) * 64'(sa_r.eta);
    sb_nxt.eta  = sa_r.eta;
    sb_nxt.e2   = eta_sq[63:8];
    sb_nxt.dm   = (dm_wide > rdu_pkg::C_CLAMP) ? rdu_pkg::C_CLAMP[31:0] : dm_wide[31:0];
    sb_nxt.cneg = !dot[35] && (dot != 36'd0);
    sb_nxt.v    = sa_r.v;
    sb_nxt.n    = sa_r.n;
    sb_nxt.back = sa_r.back;
  end

  // Stage C: cosine squared and eta times cosine.
  always_comb begin
    logic [63:0] dm_sq;
    logic [51:0] etac_full;
    dm_sq = 64'(sb_r.dm) * 64'(sb_r.dm);
    etac_full = 52'(sb_r.eta) * 52'(sb_r.dm[31:12]);
    sc_nxt.eta  = sb_r.eta;
    sc_nxt.e2   = sb_r.e2;
    sc_nxt.c2   = dm_sq[62:24];
    sc_nxt.etac = etac_full[51:16];
    sc_nxt.cneg = sb_r.cneg;
    sc_nxt.v    = sb_r.v;
    sc_nxt.n    = sb_r.n;
    sc_nxt.back = sb_r.back;
  end

  // Stage D: magnitude of cosine squared minus one.
  always_comb begin
    sd_nxt.tneg = sc_r.c2 < rdu_pkg::Q24_ONE;
    sd_nxt.mt   = sd_nxt.tneg ? (rdu_pkg::Q24_ONE - sc_r.c2) : (sc_r.c2 - rdu_pkg::Q24_ONE);
    sd_nxt.eta  = sc_r.eta;
    sd_nxt.e2   = sc_r.e2;
    sd_nxt.etac = sc_r.etac;
    sd_nxt.cneg = sc_r.cneg;
    sd_nxt.v    = sc_r.v;
    sd_nxt.n    = sc_r.n;
    sd_nxt.back = sc_r.back;
  end

  // Stage E: partial products of eta squared times that magnitude.
  always_comb begin
    se_nxt.ll   = 48'(sd_r.e2[27:0]) * 48'(sd_r.mt[19:0]);
    se_nxt.lh   = 47'(sd_r.e2[27:0]) * 47'(sd_r.mt[38:20]);
    se_nxt.hl   = 48'(sd_r.e2[55:28]) * 48'(sd_r.mt[19:0]);
    se_nxt.hh   = 47'(sd_r.e2[55:28]) * 47'(sd_r.mt[38:20]);
    se_nxt.tneg = sd_r.tneg;
    se_nxt.eta  = sd_r.eta;
    se_nxt.etac = sd_r.etac;
    se_nxt.cneg = sd_r.cneg;
    se_nxt.v    = sd_r.v;
    se_nxt.n    = sd_r.n;
    se_nxt.back = sd_r.back;
  end

  // Stage F: product sum, scaling and saturation.
  always_comb begin
    logic [94:0] full;
    logic [70:0] ptop;
    full = 95'(se_r.ll) + (95'(se_r.lh) << 20) + (95'(se_r.hl) << 28)
         + (95'(se_r.hh) << 48);
    ptop = full[94:24];
    sf_nxt.p    = (ptop > rdu_pkg::P_CAP) ? rdu_pkg::P_CAP[54:0] : ptop[54:0];
    sf_nxt.tneg = se_r.tneg;
    sf_nxt.eta  = se_r.eta;
    sf_nxt.etac = se_r.etac;
    sf_nxt.cneg = se_r.cneg;
    sf_nxt.v    = se_r.v;
    sf_nxt.n    = se_r.n;
    sf_nxt.back = se_r.back;
  end

  // Stage G: k and the total internal reflection decision.
  always_comb begin
    logic [56:0] kval;
    kval = sf_r.tneg ? (rdu_pkg::K_ONE - {2'b0, sf_r.p}) : (rdu_pkg::K_ONE + {2'b0, sf_r.p});
    sg_nxt.tir  = kval[56];
    sg_nxt.rad  = kval[56] ? 56'd0 : kval[55:0];
    sg_nxt.eta  = sf_r.eta;
    sg_nxt.etac = sf_r.etac;
    sg_nxt.cneg = sf_r.cneg;
    sg_nxt.v    = sf_r.v;
    sg_nxt.n    = sf_r.n;
    sg_nxt.back = sf_r.back;
  end

  rdu_sqrt u_k_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  ({8'b0, sg_r.rad}),
    .root (sk_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r[0].tir  <= sg_r.tir;
      s2_r[0].eta  <= sg_r.eta;
      s2_r[0].etac <= sg_r.etac;
      s2_r[0].cneg <= sg_r.cneg;
      s2_r[0].v    <= sg_r.v;
      s2_r[0].n    <= sg_r.n;
      s2_r[0].back <= sg_r.back;
      for (int i = 1; i < SL; i++) begin
        s2_r[i] <= s2_r[i-1];
      end
    end
  end

  // Stage H: normal coefficient and scaled view terms.
  always_comb begin
    logic [37:0] etac_e;
    logic [15:0] vm;
    logic [47:0] emag;
    logic        vpos;
    etac_e = {2'b0, s2_r[SL-1].etac};
    sh_nxt.bsig = (s2_r[SL-1].cneg ? (38'd0 - etac_e) : etac_e) + {6'b0, sk_root};
    for (int i = 0; i < 3; i++) begin
      vm = s2_r[SL-1].v[i][15] ? (16'd0 - s2_r[SL-1].v[i]) : s2_r[SL-1].v[i];
      vpos = !s2_r[SL-1].v[i][15] && (s2_r[SL-1].v[i] != 16'd0);
      emag = 48'(s2_r[SL-1].eta) * 48'(vm);
      sh_nxt.ev[i] = vpos ? (46'd0 - {2'b0, emag[47:4]}) : {2'b0, emag[47:4]};
    end
    sh_nxt.n    = s2_r[SL-1].n;
    sh_nxt.tir  = s2_r[SL-1].tir;
    sh_nxt.back = s2_r[SL-1].back;
  end

  // Stage I: coefficient times normal.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      si_nxt.bn[i] = $signed(sh_r.bsig) * $signed(sh_r.n[i]);
    end
    si_nxt.ev   = sh_r.ev;
    si_nxt.tir  = sh_r.tir;
    si_nxt.back = sh_r.back;
  end

  // Stage J: unnormalized refracted vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sj_nxt.r[i] = {{10{si_r.ev[i][45]}}, si_r.ev[i]} - {{2{si_r.bn[i][53]}}, si_r.bn[i]};
    end
    sj_nxt.tir  = si_r.tir;
    sj_nxt.back = si_r.back;
  end

  // Stage K: component magnitudes and signs.
  always_comb begin
    logic [55:0] mr;
    for (int i = 0; i < 3; i++) begin
      mr = sj_r.r[i][55] ? (56'd0 - sj_r.r[i]) : sj_r.r[i];
      sk_nxt.mag[i] = mr[54:0];
      sk_nxt.neg[i] = sj_r.r[i][55];
    end
    sk_nxt.tir  = sj_r.tir;
    sk_nxt.back = sj_r.back;
  end

  // Stage L: common shift that brings the largest magnitude below the limit.
  always_comb begin
    logic [54:0] orm;
    orm = sk_r.mag[0] | sk_r.mag[1] | sk_r.mag[2];
    sl_nxt.s = '0;
    for (int b = rdu_pkg::NORM_BITS; b < 55; b++) begin
      if (orm[b]) begin
        sl_nxt.s = 5'(b - rdu_pkg::NORM_BITS + 1);
      end
    end
    sl_nxt.mag  = sk_r.mag;
    sl_nxt.neg  = sk_r.neg;
    sl_nxt.tir  = sk_r.tir;
    sl_nxt.back = sk_r.back;
  end

  // Stage M: apply the shift.
  always_comb begin
    logic [54:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = sl_r.mag[i] >> sl_r.s;
      sm_nxt.a[i] = sh[29:0];
    end
    sm_nxt.neg  = sl_r.neg;
    sm_nxt.tir  = sl_r.tir;
    sm_nxt.back = sl_r.back;
  end

  // Stage N: squares.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sn_nxt.sq[i] = 60'(sm_r.a[i]) * 60'(sm_r.a[i]);
    end
    sn_nxt.a    = sm_r.a;
    sn_nxt.neg  = sm_r.neg;
    sn_nxt.tir  = sm_r.tir;
    sn_nxt.back = sm_r.back;
  end

  // Stage O: sum of squares.
  always_comb begin
    so_nxt.sum  = 62'(sn_r.sq[0]) + 62'(sn_r.sq[1]) + 62'(sn_r.sq[2]);
    so_nxt.a    = sn_r.a;
    so_nxt.neg  = sn_r.neg;
    so_nxt.tir  = sn_r.tir;
    so_nxt.back = sn_r.back;
  end

  rdu_sqrt u_len_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  ({2'b0, so_r.sum}),
    .root (len_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r[0].a    <= so_r.a;
      s3_r[0].neg  <= so_r.neg;
      s3_r[0].tir  <= so_r.tir;
      s3_r[0].back <= so_r.back;
      for (int i = 1; i < SL; i++) begin
        s3_r[i] <= s3_r[i-1];
      end
    end
  end

  // Stage P: rounded numerators and the length as divisor.
  always_comb begin
    sp_nxt.zero = (len_root == 32'd0);
    sp_nxt.den  = sp_nxt.zero ? 32'd1 : len_root;
    for (int i = 0; i < 3; i++) begin
      sp_nxt.num[i] = ({34'b0, s3_r[SL-1].a[i]} << rdu_pkg::VEC_FRAC_BITS)
                    + {33'b0, len_root[31:1]};
    end
    sp_nxt.neg  = s3_r[SL-1].neg;
    sp_nxt.tir  = s3_r[SL-1].tir;
    sp_nxt.back = s3_r[SL-1].back;
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_lane_div
    rdu_div u_dir_div (
      .clk  (clk),
      .adv  (adv),
      .num  (sp_r.num[gi]),
      .den  (sp_r.den),
      .quot (quot[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r[0].neg  <= sp_r.neg;
      s4_r[0].tir  <= sp_r.tir;
      s4_r[0].zero <= sp_r.zero;
      s4_r[0].back <= sp_r.back;
      for (int i = 1; i < DL; i++) begin
        s4_r[i] <= s4_r[i-1];
      end
    end
  end

  // Output stage: sign, saturation and the special cases.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s4_r[DL-1].tir || s4_r[DL-1].zero) begin
        dir_nxt[i] = 16'd0;
      end else if (s4_r[DL-1].neg[i]) begin
        dir_nxt[i] = (quot[i] > 32'd32768) ? 16'h8000 : 16'(32'd0 - quot[i]);
      end else begin
        dir_nxt[i] = (quot[i] > 32'd32767) ? 16'h7fff : quot[i][15:0];
      end
    end
    refr_nxt = !s4_r[DL-1].tir;
    hbn_nxt  = !s4_r[DL-1].back;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r   <= sa_nxt;
      sb_r   <= sb_nxt;
      sc_r   <= sc_nxt;
      sd_r   <= sd_nxt;
      se_r   <= se_nxt;
      sf_r   <= sf_nxt;
      sg_r   <= sg_nxt;
      sh_r   <= sh_nxt;
      si_r   <= si_nxt;
      sj_r   <= sj_nxt;
      sk_r   <= sk_nxt;
      sl_r   <= sl_nxt;
      sm_r   <= sm_nxt;
      sn_r   <= sn_nxt;
      so_r   <= so_nxt;
      sp_r   <= sp_nxt;
      dir_r  <= dir_nxt;
      refr_r <= refr_nxt;
      hbn_r  <= hbn_nxt;
    end
  end

  assign out_valid         = vld_r[TOTAL-1];
  assign out_dir_x         = dir_r[0];
  assign out_dir_y         = dir_r[1];
  assign out_dir_z         = dir_r[2];
  assign out_refracted     = refr_r;
  assign out_hit_back_next = hbn_r;

  `RDU_ASSERT_ALWAYS(a_tir_zero_dir, !out_valid || out_refracted || (out_dir_x == 16'sd0 && out_dir_y == 16'sd0 && out_dir_z == 16'sd0), "Total internal reflection with a nonzero direction.")
  `RDU_ASSERT_IMP(a_norm_shift, vld_r[POS_L], ((sl_r.mag[0] >> sl_r.s) < 55'(1 << rdu_pkg::NORM_BITS)) && ((sl_r.mag[1] >> sl_r.s) < 55'(1 << rdu_pkg::NORM_BITS)) && ((sl_r.mag[2] >> sl_r.s) < 55'(1 << rdu_pkg::NORM_BITS)), "Normalizing shift leaves a component too wide.")
  `RDU_ASSERT_IMP(a_quot_bound, vld_r[POS_DQ] && !s4_r[DL-1].tir && !s4_r[DL-1].zero, (quot[0] <= 32'(1 << rdu_pkg::VEC_FRAC_BITS)) && (quot[1] <= 32'(1 << rdu_pkg::VEC_FRAC_BITS)) && (quot[2] <= 32'(1 << rdu_pkg::VEC_FRAC_BITS)), "Normalized component exceeds one.")

endmodule
`default_nettype wire

// ----- hdl/rdu_div.sv -----
// Pipelined restoring divider with two quotient bits per stage.
`default_nettype none
module rdu_div (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quot
);

  logic [63:0] rem_r [rdu_pkg::DIV_LAT];
  logic [31:0] den_r [rdu_pkg::DIV_LAT];
  logic [31:0] quo_r [rdu_pkg::DIV_LAT];

  for (genvar g = 0; g < rdu_pkg::DIV_LAT; g++) begin : g_stage
    logic [63:0] rem_in;
    logic [31:0] den_in;
    logic [31:0] quo_in;
    logic [63:0] rem_nxt;
    logic [31:0] quo_nxt;

    if (g == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    always_comb begin
      logic [63:0] dsh;
      int j;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int t = 0; t < rdu_pkg::DIV_STEPS; t++) begin
        j = rdu_pkg::DIV_QW - 1 - g * rdu_pkg::DIV_STEPS - t;
        dsh = {32'b0, den_in} << j;
        if (rem_nxt >= dsh) begin
          rem_nxt = rem_nxt - dsh;
          quo_nxt = {quo_nxt[30:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
        quo_r[g] <= quo_nxt;
      end
    end
  end

  assign quot = quo_r[rdu_pkg::DIV_LAT-1];

endmodule
`default_nettype wire

// ----- hdl/rdu_sqrt.sv -----
// Pipelined digit-by-digit integer square root with two result bits per stage.
`default_nettype none
module rdu_sqrt (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] x_r   [rdu_pkg::SQ_LAT];
  logic [63:0] res_r [rdu_pkg::SQ_LAT];

  for (genvar g = 0; g < rdu_pkg::SQ_LAT; g++) begin : g_stage
    logic [63:0] x_in;
    logic [63:0] res_in;
    logic [63:0] x_nxt;
    logic [63:0] res_nxt;

    if (g == 0) begin : g_first
      assign x_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x_r[g-1];
      assign res_in = res_r[g-1];
    end

    always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      int i;
      x_nxt   = x_in;
      res_nxt = res_in;
      for (int t = 0; t < rdu_pkg::SQ_STEPS; t++) begin
        i = g * rdu_pkg::SQ_STEPS + t;
        bitv = 64'd1 << (62 - 2 * i);
        trial = res_nxt + bitv;
        if (x_nxt >= trial) begin
          x_nxt   = x_nxt - trial;
          res_nxt = (res_nxt >> 1) + bitv;
        end else begin
          res_nxt = res_nxt >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[g]   <= x_nxt;
        res_r[g] <= res_nxt;
      end
    end
  end

  assign root = res_r[rdu_pkg::SQ_LAT-1][31:0];

endmodule
`default_nettype wire
